[src/anxb_pkg.sv]
// ----------------------------------------------------------------------------
// anxb_pkg
// Types and constants shared by the Annex B NAL stream parser modules.
// ----------------------------------------------------------------------------
package anxb_pkg;

    // Default width of the unit byte counter
    localparam int LENGTH_BITS_DEF = 16;

    // Fixed field widths
    localparam int PAYLOAD_LEN_W = 16;
    localparam int PLI_W         = 24;

    // Depth of the command queue between front and back
    localparam int CMD_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Stream byte codes
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_START = 8'h01;
    localparam logic [7:0] BYTE_EPB   = 8'h03;

    // Header byte fields
    localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
    localparam logic [7:0] HDR_REF_IDC_MASK   = 8'h60;
    localparam logic [7:0] HDR_TYPE_MASK      = 8'h1f;
    localparam logic [4:0] UNIT_TYPE_SPS      = 5'd7;

    // Result slots of one command, in emission order
    localparam int SLOT_HDR  = 0;
    localparam int SLOT_Z1   = 1;
    localparam int SLOT_Z2   = 2;
    localparam int SLOT_PAY  = 3;
    localparam int SLOT_END  = 4;
    localparam int NUM_SLOTS = 5;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [1:0]               kind;
        logic [7:0]               data_byte;
        logic                     fz_bit;
        logic [1:0]               ref_idc;
        logic [4:0]               unit_type;
        logic [PAYLOAD_LEN_W-1:0] payload_length;
        logic [PLI_W-1:0]         profile_level_id;
        logic                     run_last;
    } t_out;

    // One classified input byte: which results it causes and their data
    typedef struct packed {
        logic [NUM_SLOTS-1:0]     slots;
        logic [7:0]               pay_byte;
        logic [7:0]               hdr_byte;
        logic [PAYLOAD_LEN_W-1:0] length;
        logic [PLI_W-1:0]         pli;
    } t_cmd;

    // Queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

[src/anxb_front.sv]
// ----------------------------------------------------------------------------
// anxb_front
// Accepts stream bytes, tracks start codes, zero runs and unit state, and
// turns each byte that causes results into one command for the back end.
// ----------------------------------------------------------------------------
module anxb_front #(
    parameter int LENGTH_BITS = anxb_pkg::LENGTH_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  anxb_pkg::t_in        i_in_data,
    input  anxb_pkg::t_fifo_stat i_fifo_stat,
    output logic                 o_push,
    output anxb_pkg::t_cmd       o_cmd
);
    import anxb_pkg::*;

    logic [1:0]             r_held, n_held;
    logic                   r_inside, n_inside;
    logic                   r_hexp, n_hexp;
    logic [7:0]             r_hdr, n_hdr;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [PLI_W-1:0]       r_cap, n_cap;
    logic [NUM_SLOTS-1:0]   slots;
    logic [7:0]             in_byte;
    logic                   eos;
    logic                   accept;

    assign in_byte    = i_in_data.stream_byte;
    assign eos        = i_in_data.end_of_stream;
    assign o_in_ready = !i_fifo_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the byte and compute the next unit state
    always_comb begin
        n_held   = r_held;
        n_inside = r_inside;
        n_hexp   = r_hexp;
        n_hdr    = r_hdr;
        n_cnt    = r_cnt;
        n_cap    = r_cap;
        slots    = '0;

        if (r_hexp) begin
            n_hdr         = in_byte;
            n_hexp        = 1'b0;
            n_inside      = 1'b1;
            n_cnt         = '0;
            n_cap         = '0;
            n_held        = 2'd0;
            slots[SLOT_HDR] = 1'b1;
        end else if (in_byte == BYTE_ZERO) begin
            if (r_held != 2'd2) begin
                n_held = r_held + 2'd1;
            end
        end else if (in_byte == BYTE_START && r_held == 2'd2) begin
            slots[SLOT_END] = r_inside;
            n_inside = 1'b0;
            n_hexp   = 1'b1;
            n_held   = 2'd0;
        end else if (r_inside) begin
            slots[SLOT_Z1]  = (r_held != 2'd0);
            slots[SLOT_Z2]  = (r_held == 2'd2);
            slots[SLOT_PAY] = !(in_byte == BYTE_EPB && r_held == 2'd2);
            n_held = 2'd0;
        end else begin
            n_held = 2'd0;
        end

        // Advance count and profile capture over the emitted payload bytes
        for (int k = SLOT_Z1; k <= SLOT_PAY; k++) begin
            if (slots[k]) begin
                if (n_cnt < LENGTH_BITS'(3)) begin
                    n_cap = {n_cap[PLI_W-9:0], (k == SLOT_PAY) ? in_byte : BYTE_ZERO};
                end
                if (!(&n_cnt)) begin
                    n_cnt = n_cnt + LENGTH_BITS'(1);
                end
            end
        end

        // Close the unit at end of stream
        if (eos) begin
            if (n_inside) begin
                slots[SLOT_END] = 1'b1;
            end
            n_inside = 1'b0;
            n_hexp   = 1'b0;
            n_held   = 2'd0;
        end
    end

    // Build the command
    always_comb begin
        o_cmd.slots    = slots;
        o_cmd.pay_byte = in_byte;
        o_cmd.hdr_byte = n_hdr;
        o_cmd.length   = PAYLOAD_LEN_W'(n_cnt);
        o_cmd.pli      = ((n_hdr & HDR_TYPE_MASK) == {3'b000, UNIT_TYPE_SPS}
                          && n_cnt >= LENGTH_BITS'(3)) ? n_cap : '0;
    end

    assign o_push = accept && (|slots);

    // Hold unit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 2'd0;
            r_inside <= 1'b0;
            r_hexp   <= 1'b0;
            r_hdr    <= '0;
            r_cnt    <= '0;
            r_cap    <= '0;
        end else if (accept) begin
            r_held   <= n_held;
            r_inside <= n_inside;
            r_hexp   <= n_hexp;
            r_hdr    <= n_hdr;
            r_cnt    <= n_cnt;
            r_cap    <= n_cap;
        end
    end

    a_hexp_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_hexp && r_inside))
        else $error("header expected while inside a unit");
    a_held_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 2'd3)
        else $error("held zero count past saturation");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fifo_stat.full |-> !o_push)
        else $error("command pushed into full queue");

endmodule

[src/anxb_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// anxb_cmd_fifo
// Short command queue that decouples the front classifier from the back
// result sequencer.
// ----------------------------------------------------------------------------
module anxb_cmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  anxb_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output anxb_pkg::t_cmd       o_head,
    output anxb_pkg::t_fifo_stat o_stat
);
    import anxb_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(CMD_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CMD_DEPTH))
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(CMD_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers disagree with count");

endmodule

[src/anxb_back.sv]
// ----------------------------------------------------------------------------
// anxb_back
// Expands each queued command into its result beats, one per cycle unless the
// output stalls, and holds them in the output register.
// ----------------------------------------------------------------------------
module anxb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  anxb_pkg::t_cmd       i_head,
    input  anxb_pkg::t_fifo_stat i_fifo_stat,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output anxb_pkg::t_out       o_out_data
);
    import anxb_pkg::*;

    logic [NUM_SLOTS-1:0] r_done;
    logic [NUM_SLOTS-1:0] rem;
    logic [NUM_SLOTS-1:0] sel;
    logic                 last;
    logic                 load;
    logic                 r_out_valid;
    t_out                 r_out;
    t_out                 beat;

    assign rem  = i_fifo_stat.empty ? '0 : (i_head.slots & ~r_done);
    assign sel  = rem & (~rem + NUM_SLOTS'(1));
    assign last = ((rem & ~sel) == '0);
    assign load = (rem != '0) && (!r_out_valid || i_out_ready);
    assign o_pop = load && last;

    // Form the next result beat from the selected slot
    always_comb begin
        beat = '0;
        beat.run_last = last;
        priority if (sel[SLOT_HDR] || sel[SLOT_END]) begin
            beat.kind          = sel[SLOT_HDR] ? KIND_HEADER : KIND_END;
            beat.fz_bit        = |(i_head.hdr_byte & HDR_FORBIDDEN_MASK);
            beat.ref_idc       = i_head.hdr_byte[6:5];
            beat.unit_type     = i_head.hdr_byte[4:0];
            if (sel[SLOT_END]) begin
                beat.payload_length   = i_head.length;
                beat.profile_level_id = i_head.pli;
            end
        end else if (sel[SLOT_PAY]) begin
            beat.kind      = KIND_PAYLOAD;
            beat.data_byte = i_head.pay_byte;
        end else begin
            beat.kind      = KIND_PAYLOAD;
            beat.data_byte = BYTE_ZERO;
        end
    end

    // Track emitted slots and hold the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_done      <= last ? '0 : (r_done | sel);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(sel))
        else $error("more than one slot selected");
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != '0) |-> (!i_fifo_stat.empty && ((r_done & ~i_head.slots) == '0)))
        else $error("emitted slots not part of head command");
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_done == '0))
        else $error("slot progress kept after pop");

endmodule

[src/annexb_nal_stream_parser.sv]
// ----------------------------------------------------------------------------
// annexb_nal_stream_parser
// A byte's command enters the command queue when the byte is accepted; its
// first result is then loaded from the queue head into the output register.
// Throughput: one byte per cycle while the queue has room; the back-end
// sequencer emits a byte's N results (up to 4) one at a time, absorbed by the
// 4-entry command queue; input ready drops while the queue is full. Reset
// (synchronous, active low) clears unit state, the queue and the output valid.
// ----------------------------------------------------------------------------
module annexb_nal_stream_parser #(
    parameter int LENGTH_BITS = anxb_pkg::LENGTH_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  anxb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output anxb_pkg::t_out o_out_data
);
    import anxb_pkg::*;

    t_fifo_stat fifo_stat;
    t_cmd       push_cmd;
    t_cmd       head_cmd;
    logic       push;
    logic       pop;

    // Classify incoming bytes
    anxb_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Queue commands
    anxb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (fifo_stat)
    );

    // Emit result beats
    anxb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_fifo_stat (fifo_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives an Annex B byte stream into the NAL stream parser and checks each
// result beat against a local parser model. A short scripted stream covers
// the special cases first. Random units, noise and broken start codes
// follow, and a closing SPS unit and a short unit run without stalls.
// Both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import anxb_pkg::*;

    localparam int                   CLK_HALF   = 6;
    localparam int                   CYCLE_CAP  = 1000000;
    localparam int                   RAND_ITEMS = 220;
    localparam int                   LONG_BYTES = 10;
    localparam logic [PAYLOAD_LEN_W-1:0] LEN_MAX = {PAYLOAD_LEN_W{1'b1}};

    typedef struct {
        logic [7:0] b;
        logic       eos;
        int         typed_n;   // -1: take the model's results
        t_out       r0;
        t_out       r1;
    } t_stim_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // Parser model state
    logic [1:0]               zeros_held   = '0;
    logic                     unit_open    = 1'b0;
    logic                     header_due   = 1'b0;
    logic [7:0]               header_byte  = '0;
    logic [PAYLOAD_LEN_W-1:0] unit_bytes   = '0;
    logic [PLI_W-1:0]         profile_bits = '0;

    t_out      beat_results[$];
    t_out      pending_results[$];
    t_stim_row script[$];

    bit gaps_on    = 1'b1;
    int stall_left = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int unit_items = 0;

    annexb_nal_stream_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always @(negedge i_clk) begin
        if (!gaps_on) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_out mk_res(input logic [1:0] kind, input logic [7:0] data,
                                    input logic fb, input logic [1:0] ref_idc,
                                    input logic [4:0] unit_type,
                                    input logic [PAYLOAD_LEN_W-1:0] len,
                                    input logic [PLI_W-1:0] pli, input logic last);
        t_out r;
        r.kind             = kind;
        r.data_byte        = data;
        r.fz_bit           = fb;
        r.ref_idc          = ref_idc;
        r.unit_type        = unit_type;
        r.payload_length   = len;
        r.profile_level_id = pli;
        r.run_last         = last;
        return r;
    endfunction

    // Bias payload toward zeros, start bytes and prevention bytes
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return BYTE_ZERO;
            3:       return BYTE_EPB;
            4:       return BYTE_START;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Emit one payload beat and update length and profile capture
    task automatic push_payload(input logic [7:0] b);
        t_out r;
        r = '0;
        if (unit_bytes < 3)
            profile_bits = {profile_bits[PLI_W-9:0], b};
        if (unit_bytes != LEN_MAX)
            unit_bytes++;
        r.kind      = KIND_PAYLOAD;
        r.data_byte = b;
        beat_results.push_back(r);
    endtask

    // Emit a header or an end summary for the current unit
    task automatic push_unit_beat(input logic [1:0] kind);
        t_out r;
        r = '0;
        r.kind          = kind;
        r.fz_bit        = |(header_byte & HDR_FORBIDDEN_MASK);
        r.ref_idc       = 2'((header_byte & HDR_REF_IDC_MASK) >> 5);
        r.unit_type     = 5'(header_byte & HDR_TYPE_MASK);
        if (kind == KIND_END) begin
            r.payload_length = unit_bytes;
            if (r.unit_type == UNIT_TYPE_SPS && unit_bytes >= 3)
                r.profile_level_id = profile_bits;
        end
        beat_results.push_back(r);
    endtask

    // Work out the results one input byte causes
    task automatic parse_beat(input logic [7:0] b, input logic eos);
        bit   epb;
        t_out r;
        beat_results.delete();
        if (header_due) begin
            header_byte  = b;
            header_due   = 1'b0;
            unit_open    = 1'b1;
            unit_bytes   = '0;
            profile_bits = '0;
            zeros_held   = '0;
            push_unit_beat(KIND_HEADER);
        end else if (b == BYTE_ZERO) begin
            if (zeros_held < 2)
                zeros_held++;
        end else if (b == BYTE_START && zeros_held >= 2) begin
            if (unit_open)
                push_unit_beat(KIND_END);
            unit_open  = 1'b0;
            header_due = 1'b1;
            zeros_held = '0;
        end else if (unit_open) begin
            // Release held zeros; drop a prevention byte after two of them
            epb = (b == BYTE_EPB && zeros_held >= 2);
            for (int i = 0; i < zeros_held; i++)
                push_payload(BYTE_ZERO);
            zeros_held = '0;
            if (!epb)
                push_payload(b);
        end else begin
            zeros_held = '0;
        end
        if (eos) begin
            if (unit_open)
                push_unit_beat(KIND_END);
            unit_open  = 1'b0;
            header_due = 1'b0;
            zeros_held = '0;
        end
        if (beat_results.size() > 0) begin
            r = beat_results.pop_back();
            r.run_last = 1'b1;
            beat_results.push_back(r);
        end
    endtask

    // Present one byte, hold it until accepted, then record its results
    task automatic send_beat(input logic [7:0] b, input logic eos, input bit keep);
        int gap;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{stream_byte: b, end_of_stream: eos};
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        parse_beat(b, eos);
        if (keep)
            foreach (beat_results[i])
                pending_results.push_back(beat_results[i]);
    endtask

    task automatic send_start_code(input logic eos);
        int zeros;
        zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
        repeat (zeros) send_beat(BYTE_ZERO, 1'b0, 1'b1);
        send_beat(BYTE_START, eos, 1'b1);
        unit_items += zeros + 1;
    endtask

    task automatic add_row(input logic [7:0] b, input logic eos, input int n,
                           input t_out r0, input t_out r1);
        t_stim_row row;
        row.b       = b;
        row.eos     = eos;
        row.typed_n = n;
        row.r0      = r0;
        row.r1      = r1;
        script.push_back(row);
    endtask

    task automatic note_mismatch(input string field, input longint want,
                                 input longint got);
        if (mismatches < 40)
            $error("%s: expected %0h, actual %0h", field, want, got);
        mismatches++;
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result kind", 0, o_out_data.kind);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.kind != want.kind)
                    note_mismatch("kind", want.kind, o_out_data.kind);
                if (o_out_data.data_byte != want.data_byte)
                    note_mismatch("data_byte", want.data_byte, o_out_data.data_byte);
                if (o_out_data.fz_bit != want.fz_bit)
                    note_mismatch("fz_bit", want.fz_bit, o_out_data.fz_bit);
                if (o_out_data.ref_idc != want.ref_idc)
                    note_mismatch("ref_idc", want.ref_idc, o_out_data.ref_idc);
                if (o_out_data.unit_type != want.unit_type)
                    note_mismatch("unit_type", want.unit_type, o_out_data.unit_type);
                if (o_out_data.payload_length != want.payload_length)
                    note_mismatch("payload_length", want.payload_length,
                                  o_out_data.payload_length);
                if (o_out_data.profile_level_id != want.profile_level_id)
                    note_mismatch("profile_level_id", want.profile_level_id,
                                  o_out_data.profile_level_id);
                if (o_out_data.run_last != want.run_last)
                    note_mismatch("run_last", want.run_last, o_out_data.run_last);
            end
        end
    end

    initial begin
        int         n;
        int         noise;
        logic [7:0] hb;
        logic       eos;

        // Scripted stream: typed rows carry their own expectations
        add_row(8'hff, 1'b0, 0, '0, '0);           // junk before any start code
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_START, 1'b0, 0, '0, '0);      // four-byte start code
        add_row(8'h67, 1'b0, 1,
                mk_res(KIND_HEADER, 8'h00, 1'b0, 2'd3, UNIT_TYPE_SPS, '0, '0, 1'b1), '0);
        add_row(8'h42, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_EPB, 1'b0, -1, '0, '0);       // emulation prevention
        add_row(BYTE_START, 1'b0, -1, '0, '0);     // 01 without zeros is payload
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);      // long zero run
        add_row(8'h05, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_START, 1'b1, -1, '0, '0);     // end of stream on a start code
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b0, -1, '0, '0);
        add_row(BYTE_START, 1'b0, -1, '0, '0);
        add_row(BYTE_ZERO, 1'b1, 2,                // zero header closed by end of stream
                mk_res(KIND_HEADER, 8'h00, 1'b0, 2'd0, 5'd0, '0, '0, 1'b0),
                mk_res(KIND_END, 8'h00, 1'b0, 2'd0, 5'd0, '0, '0, 1'b1));
        add_row(BYTE_EPB, 1'b1, 0, '0, '0);        // end of stream while idle

        // Hold reset, then release on a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            send_beat(script[i].b, script[i].eos, script[i].typed_n < 0);
            if (script[i].typed_n > 0)
                pending_results.push_back(script[i].r0);
            if (script[i].typed_n > 1)
                pending_results.push_back(script[i].r1);
        end

        // Random units, noise and broken start codes
        while (unit_items < RAND_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    noise = $urandom_range(1, 4);
                    repeat (noise)
                        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                                  1'b1);
                    unit_items += noise;
                end
                1: begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_start_code(1'b1);
                    end else begin
                        send_start_code(1'b0);
                        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                        unit_items++;
                    end
                end
                default: begin
                    send_start_code(1'b0);
                    hb = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 2) == 0)
                        hb[4:0] = UNIT_TYPE_SPS;
                    n   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(0, 12);
                    eos = ($urandom_range(0, 5) == 0);
                    send_beat(hb, eos && n == 0, 1'b1);
                    for (int k = 0; k < n; k++)
                        send_beat(payload_byte(), eos && k == n - 1, 1'b1);
                    unit_items += n + 1;
                end
            endcase
        end

        // Last part without stalls: an SPS unit, then a short unit closed by end of stream
        gaps_on = 1'b0;
        send_start_code(1'b0);
        send_beat(8'h67, 1'b0, 1'b1);
        repeat (3) send_beat(8'($urandom_range(2, 255)), 1'b0, 1'b1);
        repeat (LONG_BYTES) send_beat(payload_byte(), 1'b0, 1'b1);
        send_start_code(1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        repeat ($urandom_range(1, 6)) send_beat(payload_byte(), 1'b0, 1'b1);
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain, then wait for any stray beat
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
